// File: design/present80_block_encrypt_unit_defines.svh
// Assertion macros shared by the encrypt unit RTL.
`ifndef PRESENT80_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define PRESENT80_BLOCK_ENCRYPT_UNIT_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define PE80_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the unit clock and reset.
`define PE80_ASSERT(lbl, prop, msg) \
  `PE80_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: design/pe80_pkg.sv
// Types, constants and round functions for the PRESENT-80 encrypt unit.
package pe80_pkg;

  localparam int unsigned Rounds   = 31;
  localparam int unsigned RoundW   = $clog2(Rounds + 1);
  localparam int unsigned BlockW   = 64;
  localparam int unsigned NibbleN  = BlockW / 4;
  localparam int unsigned KeyW     = 80;
  localparam int unsigned KeyHighW = KeyW - BlockW;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b1;

  localparam logic [3:0] Sbox [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // Block and key schedule as they travel down the cell chain.
  typedef struct packed {
    logic [BlockW-1:0] blk;
    logic [KeyW-1:0]   key;
  } cell_data_t;

  function automatic logic [BlockW-1:0] round_key(input logic [KeyW-1:0] key);
    return key[KeyW-1 -: BlockW];
  endfunction

  function automatic logic [BlockW-1:0] sub_nibbles(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = '0;
    for (int n = 0; n < NibbleN; n++) begin
      y[4*n +: 4] = Sbox[x[4*n +: 4]];
    end
    return y;
  endfunction

  // Bit i moves to 16*i mod 63; the top bit stays in place.
  // Since 64 = 1 mod 63, the target is the 6-bit index rotated left by 4.
  function automatic logic [BlockW-1:0] permute_bits(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    logic [5:0]        src;
    logic [5:0]        dst;
    y = '0;
    for (int unsigned i = 0; i < BlockW; i++) begin
      src    = i[5:0];
      dst    = {src[1:0], src[5:2]};
      y[dst] = x[src];
    end
    return y;
  endfunction

endpackage

// File: design/present80_block_encrypt_unit.sv
// Top level of the PRESENT-80 encrypt unit: key registers, round chain, output stage.
//
//   channel   | direction | handshake                | payload
//   ----------+-----------+--------------------------+----------------------------
//   command   | in        | start_i, busy_o          | plaintext_i [63:0]
//   result    | out       | done_o (one-cycle beat)  | ciphertext_o [63:0]
//   config    | in        | cfg_we_i, cfg_idx_i      | cfg_wdata_i [63:0]
//
// One beat is accepted every cycle; busy_o stays low.
// Each beat runs through 31 round cells and a whitening register before its
// result appears on done_o.
// Reset clears the key registers and every stage valid bit at once.
// Results cannot be stalled; beats in flight simply advance one cell a cycle.
`include "present80_block_encrypt_unit_defines.svh"

module present80_block_encrypt_unit import pe80_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [BlockW-1:0]  plaintext_i,
  output logic               done_o,
  output logic [BlockW-1:0]  ciphertext_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [BlockW-1:0]  cfg_wdata_i
);

  logic [BlockW-1:0]   key_low_q;
  logic [KeyHighW-1:0] key_high_q;
  logic                accept;
  logic                link_vld  [Rounds+1];
  cell_data_t          link_data [Rounds+1];
  logic                done_q;
  logic [BlockW-1:0]   ct_d;
  logic [BlockW-1:0]   ct_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyLow:  key_low_q  <= cfg_wdata_i;
        CfgKeyHigh: key_high_q <= cfg_wdata_i[KeyHighW-1:0];
        default: ;
      endcase
    end
  end

  assign link_vld[0]      = accept;
  assign link_data[0].blk = plaintext_i;
  assign link_data[0].key = {key_high_q, key_low_q};

  for (genvar g = 0; g < Rounds; g++) begin : g_cell
    pe80_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_vld[g]),
      .data_i  (link_data[g]),
      .round_i (RoundW'(g + 1)),
      .valid_o (link_vld[g+1]),
      .data_o  (link_data[g+1])
    );
  end

  // final key whitening
  assign ct_d = link_data[Rounds].blk ^ round_key(link_data[Rounds].key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= link_vld[Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    ct_q <= ct_d;
  end

  assign done_o       = done_q;
  assign ciphertext_o = ct_q;

  `PE80_ASSERT(a_latency, accept |-> ##(Rounds + 1) done_o, "beat lost in round chain")
  `PE80_ASSERT(a_no_phantom, done_o |-> $past(accept, Rounds + 1), "result without a beat")
  `PE80_ASSERT(a_first_cell, accept |=> link_vld[1], "first cell missed a beat")

endmodule

// File: design/pe80_round_cell.sv
// One PRESENT round with its key schedule step, registered toward the next cell.
module pe80_round_cell import pe80_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cell_data_t        data_i,
  input  logic [RoundW-1:0] round_i,
  output logic              valid_o,
  output cell_data_t        data_o
);

  logic              valid_q;
  cell_data_t        data_d;
  cell_data_t        data_q;
  logic [KeyW-1:0]   key_rot;

  always_comb begin
    data_d.blk = permute_bits(sub_nibbles(data_i.blk ^ round_key(data_i.key)));
    // rotate left by 61, substitute the top nibble, mix in the round count
    key_rot = {data_i.key[18:0], data_i.key[KeyW-1:19]};
    key_rot[KeyW-1 -: 4] = Sbox[key_rot[KeyW-1 -: 4]];
    data_d.key = key_rot ^ ({{(KeyW - RoundW){1'b0}}, round_i} << 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
